// ===== rtl/itda_pkg.sv =====
// Shared constants for the integer to decimal ASCII converter.
// No dependencies; imported by every module of the block.
package itda_pkg;

    localparam int DIGIT_W = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef logic [DIGIT_W-1:0] bcd_digit_t;

endpackage

// ===== rtl/itda_dabble.sv =====
// One shift-add-3 step of the binary to BCD conversion.
// Depends on itda_pkg for the digit width.
module itda_dabble
    import itda_pkg::*;
#(
    parameter int NDIG = 10
)
(
    input  logic [NDIG*DIGIT_W-1:0] bcd_in,
    input  logic                    bit_in,
    output logic [NDIG*DIGIT_W-1:0] bcd_out
);

    logic [NDIG*DIGIT_W-1:0] adj;

    // digits of 5 or more get 3 added so the shift carries correctly
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_in[i*DIGIT_W +: DIGIT_W] >= bcd_digit_t'(5))
            begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W] + bcd_digit_t'(3);
            end
            else
            begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign bcd_out = {adj[NDIG*DIGIT_W-2:0], bit_in};

endmodule

// ===== rtl/int_to_decimal_ascii_unit.sv =====
// Top level: signed integer to decimal ASCII character stream.
// Depends on itda_pkg and itda_dabble.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata) takes one signed integer per item,
//   two's complement, in the low VALUE_BITS bits of s_tdata.
//   Master channel (m_tvalid/m_tready/m_tdata/m_tlast) returns its decimal text,
//   one ASCII character per item, most significant digit first, with a leading
//   '-' for negative values; m_tlast marks the final character.
// Timing:
//   After acceptance the magnitude is converted bit-serially through one
//   shift-add-3 unit. Leading zeros are then dropped one digit per cycle,
//   and characters go out one per cycle while the receiver takes them.
//   Dropped zeros plus digits always make NDIG. s_tready is high only
//   between items. The final character may still sit in the output
//   register when the next item is accepted.
//   A stalled receiver simply holds the output register and the sequencer.
//   Reset clears the sequencer and the output valid; nothing else needs it.
module int_to_decimal_ascii_unit
    import itda_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // [VALUE_BITS-1:0] number
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] character
    output logic                  m_tlast    // last_char
);

    localparam int NDIG  = ((VALUE_BITS * 1233) / 4096) + 1;
    localparam int BCD_W = NDIG * DIGIT_W;
    localparam int BCW   = $clog2(VALUE_BITS + 1);
    localparam int DCW   = $clog2(NDIG + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_STRIP = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;

    logic [2:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCW-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [DCW-1:0]        dig_cnt_reg, dig_cnt_next;
    logic                  sign_reg, sign_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    logic [VALUE_BITS-1:0] raw;
    logic [BCD_W-1:0]      bcd_step;
    bcd_digit_t            top_digit;
    logic                  slot_free;

    itda_dabble #(
        .NDIG (NDIG)
    ) u_dabble (
        .bcd_in  (bcd_reg),
        .bit_in  (mag_reg[VALUE_BITS-1]),
        .bcd_out (bcd_step)
    );

    assign raw       = s_tdata[VALUE_BITS-1:0];
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign slot_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        sign_next      = sign_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sign_next    = raw[VALUE_BITS-1];
                    // unsigned negate: the most negative value stays exact
                    mag_next     = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
                    bcd_next     = '0;
                    bit_cnt_next = BCW'(VALUE_BITS);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = bcd_step;
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BCW'(1);
                if (bit_cnt_reg == BCW'(1))
                begin
                    dig_cnt_next = DCW'(NDIG);
                    state_next   = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_digit == '0 && dig_cnt_reg != DCW'(1))
                begin
                    bcd_next     = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    dig_cnt_next = dig_cnt_reg - DCW'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        out_char_next = CHAR_MINUS;
                        out_last_next = 1'b0;
                        sign_next     = 1'b0;
                    end
                    else
                    begin
                        out_char_next = CHAR_ZERO + {4'h0, top_digit};
                        out_last_next = (dig_cnt_reg == DCW'(1));
                        bcd_next      = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        dig_cnt_next  = dig_cnt_reg - DCW'(1);
                        if (dig_cnt_reg == DCW'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        sign_reg     <= sign_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CONV))
        else $error("accepted item did not start conversion");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == CHAR_MINUS ||
                      (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE)))
        else $error("output character is not a sign or digit");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata == CHAR_MINUS) |-> !m_tlast)
        else $error("minus sign flagged as last character");

    a_strip_keeps_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STRIP || state_reg == ST_EMIT) |-> (dig_cnt_reg != '0))
        else $error("digit count ran out");

endmodule
